// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Condition implies consequence a fixed number of cycles later.
`define ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/rfpt_pkg.sv =====
// Types, constants and helpers for the rigid frame point transform.
package rfpt_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int AXIS_WIDTH      = 16;
   localparam int AXIS_FRAC       = AXIS_WIDTH - 2;
   localparam int AXIS_REG_WIDTH  = 3 * AXIS_WIDTH;
   localparam int CSR_DATA_WIDTH  = (AXIS_REG_WIDTH > COORD_WIDTH) ? AXIS_REG_WIDTH
                                                                    : COORD_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
   localparam int PROD_WIDTH      = DIFF_WIDTH + AXIS_WIDTH;
   localparam int SUM_WIDTH       = PROD_WIDTH + 2;
   localparam int SHIFT_WIDTH     = SUM_WIDTH - AXIS_FRAC;
   localparam int FINAL_WIDTH     = SHIFT_WIDTH + 1;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_AXIS   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_AXIS   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Z_AXIS   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Z = 3'd5;

   typedef enum logic {
      OP_WORLD_TO_LOCAL = 1'b0,
      OP_LOCAL_TO_WORLD = 1'b1
   } op_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [AXIS_WIDTH-1:0]  axis_comp_type;
   typedef logic [AXIS_REG_WIDTH-1:0]     axis_reg_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   typedef struct packed {
      op_type    op;
      coord_type px;
      coord_type py;
      coord_type pz;
   } req_type;

   typedef struct packed {
      coord_type qx;
      coord_type qy;
      coord_type qz;
   } rsp_type;

   typedef struct packed {
      axis_reg_type x_axis;
      axis_reg_type y_axis;
      axis_reg_type z_axis;
      coord_type    origin_x;
      coord_type    origin_y;
      coord_type    origin_z;
   } frame_type;

   // operand word between the input register and the multiplier stage
   typedef struct packed {
      op_type          op;
      diff_type [2:0]  vec;
   } opnd_type;

   // product word between the multiplier stage and the reduce stage
   typedef struct packed {
      op_type              op;
      prod_type [2:0][2:0] prod;
   } mul_type;

   localparam axis_reg_type AXIS_ONE     = AXIS_REG_WIDTH'(1) << AXIS_FRAC;
   localparam axis_reg_type X_AXIS_RESET = AXIS_ONE;
   localparam axis_reg_type Y_AXIS_RESET = AXIS_ONE << AXIS_WIDTH;
   localparam axis_reg_type Z_AXIS_RESET = AXIS_ONE << (2 * AXIS_WIDTH);

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   function automatic axis_comp_type axis_comp(input axis_reg_type r, input int unsigned k);
      return axis_comp_type'(r[k*AXIS_WIDTH +: AXIS_WIDTH]);
   endfunction

endpackage

// ===== rtl/rfpt_csr.sv =====
// Frame configuration registers: three packed axes and the origin.
module rfpt_csr (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic [rfpt_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [rfpt_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata,
   output rfpt_pkg::frame_type                       frame
);

   rfpt_pkg::frame_type frame_ff, frame_in;

   always_comb begin
      frame_in = frame_ff;
      if (csr_we) begin
         case (csr_index)
            rfpt_pkg::CSR_X_AXIS:
               frame_in.x_axis = csr_wdata[rfpt_pkg::AXIS_REG_WIDTH-1:0];
            rfpt_pkg::CSR_Y_AXIS:
               frame_in.y_axis = csr_wdata[rfpt_pkg::AXIS_REG_WIDTH-1:0];
            rfpt_pkg::CSR_Z_AXIS:
               frame_in.z_axis = csr_wdata[rfpt_pkg::AXIS_REG_WIDTH-1:0];
            rfpt_pkg::CSR_ORIGIN_X:
               frame_in.origin_x = csr_wdata[rfpt_pkg::COORD_WIDTH-1:0];
            rfpt_pkg::CSR_ORIGIN_Y:
               frame_in.origin_y = csr_wdata[rfpt_pkg::COORD_WIDTH-1:0];
            rfpt_pkg::CSR_ORIGIN_Z:
               frame_in.origin_z = csr_wdata[rfpt_pkg::COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff.x_axis   <= rfpt_pkg::X_AXIS_RESET;
         frame_ff.y_axis   <= rfpt_pkg::Y_AXIS_RESET;
         frame_ff.z_axis   <= rfpt_pkg::Z_AXIS_RESET;
         frame_ff.origin_x <= '0;
         frame_ff.origin_y <= '0;
         frame_ff.origin_z <= '0;
      end else begin
         frame_ff <= frame_in;
      end
   end

   assign frame = frame_ff;

endmodule

// ===== rtl/rfpt_mult.sv =====
// Multiplier stage: nine axis-by-coordinate products, registered.
module rfpt_mult (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 opnd_valid,
   input  rfpt_pkg::opnd_type   opnd,
   input  rfpt_pkg::frame_type  frame,
   output logic                 mul_valid,
   output rfpt_pkg::mul_type    mul
);

   logic                mul_valid_ff, mul_valid_in;
   rfpt_pkg::mul_type   mul_ff, mul_in;

   always_comb begin
      rfpt_pkg::axis_reg_type  axis [3];
      rfpt_pkg::axis_comp_type m;
      rfpt_pkg::diff_type      v;
      rfpt_pkg::prod_type      p;
      axis[0] = frame.x_axis;
      axis[1] = frame.y_axis;
      axis[2] = frame.z_axis;
      mul_in.op = opnd.op;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            // local to world uses the transposed matrix
            if (opnd.op == rfpt_pkg::OP_LOCAL_TO_WORLD) begin
               m = rfpt_pkg::axis_comp(axis[j], i);
            end else begin
               m = rfpt_pkg::axis_comp(axis[i], j);
            end
            v = $signed(opnd.vec[j]);
            p = m * v;
            mul_in.prod[i][j] = p;
         end
      end
      mul_valid_in = opnd_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
   end

   assign mul_valid = mul_valid_ff;
   assign mul       = mul_ff;

endmodule

// ===== rtl/rfpt_reduce.sv =====
// Reduce stage: sum products, floor shift, add origin (local to world), saturate, register result.
module rfpt_reduce (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 mul_valid,
   input  rfpt_pkg::mul_type    mul,
   input  rfpt_pkg::frame_type  frame,
   output logic                 rsp_valid,
   output rfpt_pkg::rsp_type    rsp_data
);

   localparam logic signed [rfpt_pkg::FINAL_WIDTH-1:0] SAT_HI =
      rfpt_pkg::FINAL_WIDTH'(rfpt_pkg::COORD_MAX);
   localparam logic signed [rfpt_pkg::FINAL_WIDTH-1:0] SAT_LO =
      rfpt_pkg::FINAL_WIDTH'(rfpt_pkg::COORD_MIN);

   logic                rsp_valid_ff, rsp_valid_in;
   rfpt_pkg::rsp_type   rsp_ff, rsp_in;

   always_comb begin
      rfpt_pkg::coord_type                    origin [3];
      rfpt_pkg::coord_type                    offs;
      rfpt_pkg::coord_type                    q [3];
      logic signed [rfpt_pkg::SUM_WIDTH-1:0]   sum;
      logic signed [rfpt_pkg::SHIFT_WIDTH-1:0] shifted;
      logic signed [rfpt_pkg::FINAL_WIDTH-1:0] total;
      origin[0] = frame.origin_x;
      origin[1] = frame.origin_y;
      origin[2] = frame.origin_z;
      for (int i = 0; i < 3; i++) begin
         sum = $signed(mul.prod[i][0]) + $signed(mul.prod[i][1]) + $signed(mul.prod[i][2]);
         shifted = rfpt_pkg::SHIFT_WIDTH'(sum >>> rfpt_pkg::AXIS_FRAC);
         offs = (mul.op == rfpt_pkg::OP_LOCAL_TO_WORLD) ? origin[i] : '0;
         total = shifted + offs;
         if (total > SAT_HI) begin
            q[i] = rfpt_pkg::COORD_MAX;
         end else if (total < SAT_LO) begin
            q[i] = rfpt_pkg::COORD_MIN;
         end else begin
            q[i] = total[rfpt_pkg::COORD_WIDTH-1:0];
         end
      end
      rsp_in.qx    = q[0];
      rsp_in.qy    = q[1];
      rsp_in.qz    = q[2];
      rsp_valid_in = mul_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/rigid_frame_point_transform.sv =====
// Top level of the rigid frame point transform: input register and stage wiring.
//
//   channel  ports                             handshake
//   request  start, busy, req_data             word taken when start && !busy
//   response rsp_valid, rsp_data               word shown for one cycle on rsp_valid
//   config   csr_we, csr_index, csr_wdata      register written when csr_we
//
// One word per cycle through the input register (origin subtract for world to local),
// multiplier register (nine products), result register (sum, shift, origin add for local
// to world, saturate). busy is always low. The response side cannot stall.
// Synchronous active-high reset clears the valid pipeline and loads the
// identity frame with the origin at zero.
`include "assert_macros.svh"

module rigid_frame_point_transform (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  rfpt_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   output rfpt_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [rfpt_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rfpt_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   rfpt_pkg::frame_type frame;
   logic                opnd_valid_ff, opnd_valid_in;
   rfpt_pkg::opnd_type  opnd_ff, opnd_in;
   logic                mul_valid;
   rfpt_pkg::mul_type   mul;

   rfpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .frame     (frame)
   );

   assign busy = 1'b0;

   always_comb begin
      rfpt_pkg::coord_type p [3];
      rfpt_pkg::coord_type o [3];
      p[0] = req_data.px;
      p[1] = req_data.py;
      p[2] = req_data.pz;
      o[0] = frame.origin_x;
      o[1] = frame.origin_y;
      o[2] = frame.origin_z;
      opnd_in.op = req_data.op;
      for (int j = 0; j < 3; j++) begin
         if (req_data.op == rfpt_pkg::OP_LOCAL_TO_WORLD) begin
            opnd_in.vec[j] = rfpt_pkg::diff_type'($signed(p[j]));
         end else begin
            opnd_in.vec[j] = rfpt_pkg::diff_type'($signed(p[j])) -
                             rfpt_pkg::diff_type'($signed(o[j]));
         end
      end
      opnd_valid_in = start && !busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opnd_valid_ff <= 1'b0;
      end else begin
         opnd_valid_ff <= opnd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
   end

   rfpt_mult u_mult (
      .clock      (clock),
      .reset      (reset),
      .opnd_valid (opnd_valid_ff),
      .opnd       (opnd_ff),
      .frame      (frame),
      .mul_valid  (mul_valid),
      .mul        (mul)
   );

   rfpt_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .mul_valid (mul_valid),
      .mul       (mul),
      .frame     (frame),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // every accepted word comes out on rsp_valid after the input, multiplier and result registers
   `ASSERT_DELAY(a_accept_to_rsp, clock, reset, start && !busy, 3, rsp_valid)
   // no response without an earlier accepted word behind it
   `ASSERT_IMPLY(a_rsp_has_source, clock, reset, rsp_valid, $past(start && !busy, 3))
   // product stage only runs on an accepted word passed on by the input register
   `ASSERT_IMPLY(a_mul_has_source, clock, reset, mul_valid, $past(start && !busy, 2))

endmodule
